@@ rtl/grrud_pkg.sv @@
`default_nettype none
package grrud_pkg;

    // request kinds
    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_REMOVE  = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    // group modes
    localparam logic [1:0] MODE_ONE      = 2'd0;
    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_PASS     = 2'd2;
    localparam logic [1:0] MODE_PASS_ALT = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOGROUP = 2'd1;
    localparam logic [1:0] STAT_NOMEMB  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    localparam int ENTRY_W = 17;

    typedef struct packed {
        logic        copy_request;
        logic [63:0] update_tag;
        logic [1:0]  mode;
        logic [15:0] quota;
        logic [2:0]  group_slot;
        logic [15:0] consumer_id;
        logic [1:0]  kind;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       handled;
        logic       forward;
    } res_t;

    // one member table entry
    typedef struct packed {
        logic [15:0] id;
        logic        fresh;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_CURRD,
        ST_CURCAP,
        ST_CSCAN,
        ST_ORDER,
        ST_DIST,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/group_round_robin_update_distributor.sv @@
// Group round-robin update distributor.
// Input channel s_*: one request per beat; s_tuser carries the kind (add
// consumer, remove consumer, update request), s_tdata the payload.
// Result channel m_*: exactly one result per request, in request order,
// carrying forward, handled and status.
// Requests are handled one at a time by a sequencer around the member table
// memory (one read and one write port, registered read data).
//   add, unknown kind, refused request: straight from accept to result
//   update request: scans the members of the group
//   remove: find, close the gap, re-seat the cursor
// The result sits in an output register, so the sequencer returns to idle
// and takes the next request while the result waits for m_tready; when a
// second result is ready before the first is taken, the sequencer holds it
// and s_tready stays low.
// Reset (aresetn low, synchronous) empties all groups and the turn order;
// member table contents need no clearing.
`default_nettype none
module group_round_robin_update_distributor
    import grrud_pkg::*;
#(
    parameter int MAX_GROUPS  = 8,
    parameter int MAX_MEMBERS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // consumer_id[15:0], group_slot[18:16], quota[34:19], mode[36:35],
    // update_tag[100:37], copy_request[101], zero fill [103:102]
    input  wire logic [103:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // forward[0], handled[1], status[3:2], zero fill [7:4]
    output logic [7:0]        m_tdata
);

    in_item_t in_item;
    res_t     core_res;
    logic     core_res_valid, core_res_ready;
    res_t     out_reg;
    logic     out_valid_reg;

    // unpack the request
    assign in_item = '{
        copy_request: s_tdata[101],
        update_tag:   s_tdata[100:37],
        mode:         s_tdata[36:35],
        quota:        s_tdata[34:19],
        group_slot:   s_tdata[18:16],
        consumer_id:  s_tdata[15:0],
        kind:         s_tuser
    };

    grrud_core #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_MEMBERS(MAX_MEMBERS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .res_valid(core_res_valid),
        .res_ready(core_res_ready),
        .res      (core_res)
    );

    // output register
    assign core_res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_res_ready) begin
            out_valid_reg <= core_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_res_ready && core_res_valid) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.status, out_reg.handled, out_reg.forward};

endmodule
`default_nettype wire

@@ rtl/grrud_ram.sv @@
`default_nettype none
module grrud_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/grrud_core.sv @@
`default_nettype none
module grrud_core
    import grrud_pkg::*;
#(
    parameter int MAX_GROUPS  = 8,
    parameter int MAX_MEMBERS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          res_valid,
    input  wire logic     res_ready,
    output res_t          res
);

    localparam int GW    = $clog2(MAX_GROUPS);
    localparam int MW    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW    = $clog2(MAX_MEMBERS + 1);
    localparam int OW    = $clog2(MAX_GROUPS + 1);
    localparam int AW    = GW + MW;
    localparam int DEPTH = 2 ** AW;

    // per-group state
    logic          g_valid_reg     [MAX_GROUPS];
    logic          g_valid_next    [MAX_GROUPS];
    logic [1:0]    g_mode_reg      [MAX_GROUPS];
    logic [1:0]    g_mode_next     [MAX_GROUPS];
    logic [15:0]   g_quota_reg     [MAX_GROUPS];
    logic [15:0]   g_quota_next    [MAX_GROUPS];
    logic [15:0]   g_count_reg     [MAX_GROUPS];
    logic [15:0]   g_count_next    [MAX_GROUPS];
    logic [63:0]   g_tag_reg       [MAX_GROUPS];
    logic [63:0]   g_tag_next      [MAX_GROUPS];
    logic          g_tag_valid_reg [MAX_GROUPS];
    logic          g_tag_valid_next[MAX_GROUPS];
    logic [CW-1:0] g_size_reg      [MAX_GROUPS];
    logic [CW-1:0] g_size_next     [MAX_GROUPS];
    logic [CW-1:0] m_cursor_reg    [MAX_GROUPS];
    logic [CW-1:0] m_cursor_next   [MAX_GROUPS];
    logic [GW-1:0] order_reg       [MAX_GROUPS];
    logic [GW-1:0] order_next      [MAX_GROUPS];

    // global state
    logic [OW-1:0] order_len_reg, order_len_next;
    logic [OW-1:0] order_cur_reg, order_cur_next;
    logic [63:0]   glob_tag_reg, glob_tag_next;
    logic          glob_tag_valid_reg, glob_tag_valid_next;
    logic [15:0]   tally_reg, tally_next;

    // sequencer
    state_t        state_reg, state_next;
    in_item_t      item_reg, item_next;
    logic [15:0]   target_reg, target_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic          have_cur_reg, have_cur_next;
    res_t          res_reg, res_next;

    // member table port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    // helpers
    logic [GW-1:0] gi, gin;
    logic          in_slot_ok, hit;
    logic [CW-1:0] size_cur, cur_inc;
    logic [OW-1:0] oc_eff;
    logic [CW-1:0] mc_eff;
    logic          newtag, ord_found;
    logic [15:0]   cnt_all, tally_all, cnt_one;
    logic [OW-1:0] ord_pos;

    grrud_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_members (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rdata_raw)
    );
    assign ram_rdata = entry_t'(rdata_raw);

    assign gi         = GW'(item_reg.group_slot);
    assign gin        = GW'(in_item.group_slot);
    assign in_slot_ok = (32'(in_item.group_slot) < MAX_GROUPS);
    assign hit        = pend_reg && (ram_rdata.id == target_reg);
    assign size_cur   = g_size_reg[gi];
    assign cur_inc    = (pend_idx_reg == m_cursor_reg[gi]) ? m_cursor_reg[gi] + 1'b1
                                                           : m_cursor_reg[gi];
    assign oc_eff     = (order_cur_reg >= order_len_reg) ? '0 : order_cur_reg;
    assign mc_eff     = (m_cursor_reg[gi] >= size_cur) ? '0 : m_cursor_reg[gi];
    assign newtag     = !g_tag_valid_reg[gi] || (g_tag_reg[gi] != item_reg.update_tag);
    assign cnt_all    = newtag ? g_count_reg[gi] + 16'd1 : g_count_reg[gi];
    assign tally_all  = (newtag ? 16'd0 : tally_reg) + 16'd1;
    assign cnt_one    = g_count_reg[gi] + 16'd1;
    assign res        = res_reg;

    // first position of the current group in the turn order
    always_comb begin
        ord_found = 1'b0;
        ord_pos   = '0;
        for (int k = MAX_GROUPS - 1; k >= 0; k--) begin
            if (OW'(k) < order_len_reg && order_reg[k] == gi) begin
                ord_found = 1'b1;
                ord_pos   = OW'(k);
            end
        end
    end

    // sequencer: next state and table updates
    always_comb begin
        g_valid_next        = g_valid_reg;
        g_mode_next         = g_mode_reg;
        g_quota_next        = g_quota_reg;
        g_count_next        = g_count_reg;
        g_tag_next          = g_tag_reg;
        g_tag_valid_next    = g_tag_valid_reg;
        g_size_next         = g_size_reg;
        m_cursor_next       = m_cursor_reg;
        order_next          = order_reg;
        order_len_next      = order_len_reg;
        order_cur_next      = order_cur_reg;
        glob_tag_next       = glob_tag_reg;
        glob_tag_valid_next = glob_tag_valid_reg;
        tally_next          = tally_reg;
        state_next          = state_reg;
        item_next           = item_reg;
        target_next         = target_reg;
        rd_idx_next         = rd_idx_reg;
        pend_next           = pend_reg;
        pend_idx_next       = pend_idx_reg;
        cur_next            = cur_reg;
        have_cur_next       = have_cur_reg;
        res_next            = res_reg;
        ram_we              = 1'b0;
        ram_waddr           = '0;
        ram_wdata           = '0;
        ram_raddr           = '0;
        in_ready            = 1'b0;
        res_valid           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next   = in_item;
                    target_next = in_item.consumer_id;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    res_next    = '{status: STAT_OK, handled: 1'b1, forward: 1'b0};
                    state_next  = ST_DONE;
                    unique case (in_item.kind)
                        KIND_ADD: begin
                            if (!in_slot_ok) begin
                                res_next.status = STAT_FULL;
                            end else if (g_valid_reg[gin] &&
                                         32'(g_size_reg[gin]) >= MAX_MEMBERS) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                // create the group on first add
                                if (!g_valid_reg[gin]) begin
                                    g_valid_next[gin]     = 1'b1;
                                    g_mode_next[gin]      = in_item.mode;
                                    g_quota_next[gin]     = in_item.quota;
                                    g_count_next[gin]     = '0;
                                    g_tag_next[gin]       = '0;
                                    g_tag_valid_next[gin] = 1'b0;
                                    if (32'(order_len_reg) < MAX_GROUPS) begin
                                        if (order_cur_reg == order_len_reg) begin
                                            order_cur_next = order_cur_reg + 1'b1;
                                        end
                                        order_next[order_len_reg[GW-1:0]] = gin;
                                        order_len_next = order_len_reg + 1'b1;
                                    end
                                    m_cursor_next[gin] = CW'(1);
                                    g_size_next[gin]   = CW'(1);
                                    ram_waddr          = {gin, MW'(0)};
                                end else begin
                                    if (m_cursor_reg[gin] == g_size_reg[gin]) begin
                                        m_cursor_next[gin] = g_size_reg[gin] + 1'b1;
                                    end
                                    g_size_next[gin] = g_size_reg[gin] + 1'b1;
                                    ram_waddr        = {gin, g_size_reg[gin][MW-1:0]};
                                end
                                ram_we    = 1'b1;
                                ram_wdata = '{id: in_item.consumer_id, fresh: 1'b1};
                            end
                        end
                        KIND_REMOVE: begin
                            if (!in_slot_ok || !g_valid_reg[gin]) begin
                                res_next.status = STAT_NOGROUP;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_REQUEST: begin
                            if (!in_item.copy_request) begin
                                res_next.handled = 1'b0;
                            end else if (!in_slot_ok || !g_valid_reg[gin]) begin
                                res_next.status = STAT_NOGROUP;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // look for the first member with the request's id
            ST_SCAN: begin
                if (hit) begin
                    if (item_reg.kind == KIND_REMOVE) begin
                        have_cur_next = cur_inc < size_cur;
                        cur_next      = (cur_inc > pend_idx_reg) ? cur_inc - 1'b1 : cur_inc;
                        rd_idx_next   = pend_idx_reg + 1'b1;
                        pend_next     = 1'b0;
                        state_next    = ST_SHIFT;
                    end else if (ram_rdata.fresh) begin
                        ram_we           = 1'b1;
                        ram_waddr        = {gi, pend_idx_reg[MW-1:0]};
                        ram_wdata        = '{id: item_reg.consumer_id, fresh: 1'b0};
                        res_next.forward = 1'b1;
                        state_next       = ST_DONE;
                    end else begin
                        state_next = ST_ORDER;
                    end
                end else if (rd_idx_reg < size_cur) begin
                    ram_raddr     = {gi, rd_idx_reg[MW-1:0]};
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else begin
                    res_next.status = STAT_NOMEMB;
                    state_next      = ST_DONE;
                end
            end

            // close the gap: entry k moves down to k-1
            ST_SHIFT: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = {gi, MW'(pend_idx_reg - 1'b1)};
                    ram_wdata = ram_rdata;
                end
                if (rd_idx_reg < size_cur) begin
                    ram_raddr     = {gi, rd_idx_reg[MW-1:0]};
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else begin
                    pend_next       = 1'b0;
                    g_size_next[gi] = size_cur - 1'b1;
                    if (size_cur == CW'(1)) begin
                        // last member gone: drop the group from the turn order
                        g_valid_next[gi]  = 1'b0;
                        m_cursor_next[gi] = '0;
                        if (ord_found) begin
                            for (int k = 0; k < MAX_GROUPS - 1; k++) begin
                                if (OW'(k) >= ord_pos) begin
                                    order_next[k] = order_reg[k + 1];
                                end
                            end
                            order_len_next = order_len_reg - 1'b1;
                            if (ord_pos < order_cur_reg) begin
                                order_cur_next = order_cur_reg - 1'b1;
                            end
                        end
                        state_next = ST_DONE;
                    end else if (have_cur_reg) begin
                        state_next = ST_CURRD;
                    end else begin
                        m_cursor_next[gi] = size_cur - 1'b1;
                        state_next        = ST_DONE;
                    end
                end
            end

            // fetch the id under the consumer cursor
            ST_CURRD: begin
                ram_raddr  = {gi, cur_reg[MW-1:0]};
                state_next = ST_CURCAP;
            end

            ST_CURCAP: begin
                target_next = ram_rdata.id;
                rd_idx_next = '0;
                pend_next   = 1'b0;
                state_next  = ST_CSCAN;
            end

            // cursor lands on the first match of that id
            ST_CSCAN: begin
                if (hit) begin
                    m_cursor_next[gi] = pend_idx_reg;
                    state_next        = ST_DONE;
                end else if (rd_idx_reg < size_cur) begin
                    ram_raddr     = {gi, rd_idx_reg[MW-1:0]};
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else begin
                    m_cursor_next[gi] = size_cur;
                    state_next        = ST_DONE;
                end
            end

            // turn checks, all-in-group accounting, pass-mode forwarding
            ST_ORDER: begin
                state_next = ST_DONE;
                if (order_len_reg != '0) begin
                    order_cur_next = oc_eff;
                    if (order_reg[oc_eff[GW-1:0]] == gi) begin
                        m_cursor_next[gi] = mc_eff;
                        if (!(glob_tag_valid_reg && glob_tag_reg == item_reg.update_tag)) begin
                            if (g_mode_reg[gi] == MODE_ONE) begin
                                ram_raddr  = {gi, mc_eff[MW-1:0]};
                                state_next = ST_DIST;
                            end else if (g_mode_reg[gi] == MODE_ALL) begin
                                res_next.forward = 1'b1;
                                if (newtag) begin
                                    g_tag_next[gi]       = item_reg.update_tag;
                                    g_tag_valid_next[gi] = 1'b1;
                                end
                                g_count_next[gi] = cnt_all;
                                tally_next       = tally_all;
                                if (tally_all == 16'(size_cur) && cnt_all >= g_quota_reg[gi]) begin
                                    glob_tag_next       = item_reg.update_tag;
                                    glob_tag_valid_next = 1'b1;
                                    g_count_next[gi]    = '0;
                                    order_cur_next      = oc_eff + 1'b1;
                                end
                            end else begin
                                res_next.forward = 1'b1;
                            end
                        end
                    end
                end
            end

            // one-per-group: only the current consumer gets it
            ST_DIST: begin
                state_next = ST_DONE;
                if (ram_rdata.id == item_reg.consumer_id) begin
                    res_next.forward     = 1'b1;
                    glob_tag_next        = item_reg.update_tag;
                    glob_tag_valid_next  = 1'b1;
                    g_tag_next[gi]       = item_reg.update_tag;
                    g_tag_valid_next[gi] = 1'b1;
                    g_count_next[gi]     = cnt_one;
                    if (cnt_one >= g_quota_reg[gi]) begin
                        m_cursor_next[gi] = m_cursor_reg[gi] + 1'b1;
                        g_count_next[gi]  = '0;
                        order_cur_next    = order_cur_reg + 1'b1;
                    end
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            order_len_reg      <= '0;
            order_cur_reg      <= '0;
            glob_tag_valid_reg <= 1'b0;
            tally_reg          <= '0;
            pend_reg           <= 1'b0;
            for (int k = 0; k < MAX_GROUPS; k++) begin
                g_valid_reg[k]     <= 1'b0;
                g_tag_valid_reg[k] <= 1'b0;
                g_size_reg[k]      <= '0;
                m_cursor_reg[k]    <= '0;
                g_count_reg[k]     <= '0;
            end
        end else begin
            state_reg          <= state_next;
            order_len_reg      <= order_len_next;
            order_cur_reg      <= order_cur_next;
            glob_tag_valid_reg <= glob_tag_valid_next;
            tally_reg          <= tally_next;
            pend_reg           <= pend_next;
            g_valid_reg        <= g_valid_next;
            g_tag_valid_reg    <= g_tag_valid_next;
            g_size_reg         <= g_size_next;
            m_cursor_reg       <= m_cursor_next;
            g_count_reg        <= g_count_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        g_mode_reg    <= g_mode_next;
        g_quota_reg   <= g_quota_next;
        g_tag_reg     <= g_tag_next;
        order_reg     <= order_next;
        glob_tag_reg  <= glob_tag_next;
        item_reg      <= item_next;
        target_reg    <= target_next;
        rd_idx_reg    <= rd_idx_next;
        pend_idx_reg  <= pend_idx_next;
        cur_reg       <= cur_next;
        have_cur_reg  <= have_cur_next;
        res_reg       <= res_next;
    end

    a_cursor_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        order_cur_reg <= order_len_reg)
        else $error("turn cursor beyond order length");

    a_order_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(order_len_reg) <= MAX_GROUPS)
        else $error("turn order overflow");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> state_reg != ST_IDLE)
        else $error("accepted request left sequencer idle");

    a_shift_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && pend_reg) |-> pend_idx_reg != '0)
        else $error("shift writes below entry zero");

endmodule
`default_nettype wire

@@ tb/distributor_checker.sv @@
`default_nettype none
module distributor_checker
    import grrud_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [103:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [7:0]   m_tdata,
    output int                fail_count,
    output int                pending
);

    localparam int NG = 8;
    localparam int NM = 16;

    // shadow copy of the distributor state
    logic        grp_valid [NG];
    logic [1:0]  grp_mode [NG];
    logic [15:0] grp_quota [NG];
    logic [15:0] grp_count [NG];
    logic [63:0] grp_tag [NG];
    logic        grp_tag_ok [NG];
    int          grp_size [NG];
    int          grp_cur [NG];
    logic [15:0] memb_id [NG][NM];
    logic        memb_fresh [NG][NM];
    int          turn_list [NG];
    int          turn_len;
    int          turn_cur;
    logic [63:0] last_sent_tag;
    logic        last_sent_ok;
    logic [15:0] all_tally;

    res_t expected_results[$];

    assign pending = expected_results.size();

    function automatic int find_memb(int g, logic [15:0] id);
        for (int i = 0; i < grp_size[g]; i++)
            if (memb_id[g][i] == id) return i;
        return grp_size[g];
    endfunction

    function automatic logic [1:0] join_consumer(logic [15:0] id, int g,
                                                 logic [15:0] q, logic [1:0] md);
        int n;
        if (!grp_valid[g]) begin
            grp_valid[g] = 1'b1;
            grp_mode[g] = md;
            grp_quota[g] = q;
            grp_count[g] = '0;
            grp_tag[g] = '0;
            grp_tag_ok[g] = 1'b0;
            grp_size[g] = 0;
            grp_cur[g] = 0;
            if (turn_len < NG) begin
                if (turn_cur == turn_len) turn_cur++;
                turn_list[turn_len] = g;
                turn_len++;
            end
        end
        n = grp_size[g];
        if (n >= NM) return STAT_FULL;
        if (grp_cur[g] == n) grp_cur[g] = n + 1;
        memb_id[g][n] = id;
        memb_fresh[g][n] = 1'b1;
        grp_size[g] = n + 1;
        return STAT_OK;
    endfunction

    function automatic logic [1:0] drop_consumer(logic [15:0] id, int g);
        int pos, n, cur, i;
        logic have_cur;
        logic [15:0] cur_id;
        if (!grp_valid[g]) return STAT_NOGROUP;
        n = grp_size[g];
        pos = find_memb(g, id);
        if (pos >= n) return STAT_NOMEMB;
        cur = grp_cur[g];
        if (pos == cur) cur++;
        have_cur = cur < n;
        cur_id = have_cur ? memb_id[g][cur] : '0;
        for (i = pos; i + 1 < n; i++) begin
            memb_id[g][i] = memb_id[g][i+1];
            memb_fresh[g][i] = memb_fresh[g][i+1];
        end
        n--;
        grp_size[g] = n;
        grp_cur[g] = have_cur ? find_memb(g, cur_id) : n;
        if (n == 0) begin
            grp_valid[g] = 1'b0;
            for (i = 0; i < turn_len; i++)
                if (turn_list[i] == g) break;
            if (i < turn_len) begin
                for (int k = i; k + 1 < turn_len; k++) turn_list[k] = turn_list[k+1];
                turn_len--;
                if (i < turn_cur) turn_cur--;
            end
        end
        return STAT_OK;
    endfunction

    // round-robin decision for a non-fresh consumer
    function automatic logic take_turn(logic [15:0] id, int g, logic [63:0] tag);
        int mc;
        if (turn_len == 0) return 1'b0;
        if (turn_cur >= turn_len) turn_cur = 0;
        if (turn_list[turn_cur] != g) return 1'b0;
        if (grp_cur[g] >= grp_size[g]) grp_cur[g] = 0;
        if (last_sent_ok && last_sent_tag == tag) return 1'b0;
        if (grp_mode[g] == MODE_ONE) begin
            mc = grp_cur[g];
            if (mc >= grp_size[g] || memb_id[g][mc] != id) return 1'b0;
            last_sent_tag = tag;
            last_sent_ok = 1'b1;
            grp_tag[g] = tag;
            grp_tag_ok[g] = 1'b1;
            grp_count[g] = grp_count[g] + 16'd1;
            if (grp_count[g] >= grp_quota[g]) begin
                grp_cur[g] = mc + 1;
                grp_count[g] = '0;
                turn_cur++;
            end
            return 1'b1;
        end
        if (grp_mode[g] == MODE_ALL) begin
            if (!grp_tag_ok[g] || grp_tag[g] != tag) begin
                grp_tag[g] = tag;
                grp_tag_ok[g] = 1'b1;
                grp_count[g] = grp_count[g] + 16'd1;
                all_tally = '0;
            end
            all_tally = all_tally + 16'd1;
            if (32'(all_tally) == grp_size[g] && grp_count[g] >= grp_quota[g]) begin
                last_sent_tag = tag;
                last_sent_ok = 1'b1;
                grp_count[g] = '0;
                turn_cur++;
            end
        end
        return 1'b1;
    endfunction

    function automatic res_t predict_result(in_item_t it);
        res_t r;
        int g, pos;
        r = '0;
        r.handled = 1'b1;
        r.status = STAT_OK;
        g = int'(it.group_slot);
        case (it.kind)
            KIND_ADD: r.status = join_consumer(it.consumer_id, g, it.quota, it.mode);
            KIND_REMOVE: r.status = drop_consumer(it.consumer_id, g);
            KIND_REQUEST: begin
                if (!it.copy_request) begin
                    r.handled = 1'b0;
                end else if (!grp_valid[g]) begin
                    r.status = STAT_NOGROUP;
                end else begin
                    pos = find_memb(g, it.consumer_id);
                    if (pos >= grp_size[g]) begin
                        r.status = STAT_NOMEMB;
                    end else if (memb_fresh[g][pos]) begin
                        memb_fresh[g][pos] = 1'b0;
                        r.forward = 1'b1;
                    end else begin
                        r.forward = take_turn(it.consumer_id, g, it.update_tag);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge aclk) begin
        in_item_t it;
        res_t exp_r, got;
        if (!aresetn) begin
            for (int g = 0; g < NG; g++) begin
                grp_valid[g] <= 1'b0; grp_mode[g] <= '0; grp_quota[g] <= '0;
                grp_count[g] <= '0; grp_tag[g] <= '0; grp_tag_ok[g] <= 1'b0;
                grp_size[g] <= 0; grp_cur[g] <= 0; turn_list[g] <= 0;
            end
            turn_len <= 0;
            turn_cur <= 0;
            last_sent_tag <= '0;
            last_sent_ok <= 1'b0;
            all_tally <= '0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[3:0]);
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.forward !== exp_r.forward) begin
                        $error("forward: expected %0d, got %0d", exp_r.forward, got.forward);
                        fail_count = fail_count + 1;
                    end
                    if (got.handled !== exp_r.handled) begin
                        $error("handled: expected %0d, got %0d", exp_r.handled, got.handled);
                        fail_count = fail_count + 1;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, got.status);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it = in_item_t'({s_tdata[101:0], s_tuser});
                expected_results.insert(expected_results.size(), predict_result(it));
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
    import grrud_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    int           fail_count;
    int           pending;
    logic         long_hold = 1'b0;
    logic         hold_done = 1'b0;

    always #10 aclk = ~aclk;

    group_round_robin_update_distributor dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    distributor_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending
    );

    // send one request, bursts with random gaps between them
    task automatic send_request(logic [1:0] kind, logic [15:0] id, logic [2:0] g,
                                logic [15:0] q, logic [1:0] md, logic [63:0] tag,
                                logic cp);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {2'b00, cp, tag, md, q, g, id};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    // receiver stall pattern plus one long hold-off
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge aclk);
            if (long_hold && !hold_done) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_done <= 1'b1;
            end
            phase++;
            if ((phase / 200) % 2 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [15:0] ids [8][4];
        int g, k;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: error paths, extremes, one, all and pass modes, fresh and duplicate ids
        send_request(KIND_REQUEST, 16'h0, 3'd0, 16'd1, MODE_ONE, 64'h0, 1'b1);
        send_request(KIND_REMOVE, 16'h1, 3'd0, 16'd1, MODE_ONE, 64'h0, 1'b0);
        send_request(KIND_NOP, 16'hffff, 3'd7, 16'hffff, MODE_PASS_ALT, '1, 1'b1);
        send_request(KIND_ADD, 16'hffff, 3'd7, 16'hffff, MODE_ONE, '1, 1'b1);
        send_request(KIND_ADD, 16'h0000, 3'd0, 16'd1, MODE_ALL, 64'h0, 1'b0);
        send_request(KIND_ADD, 16'h0001, 3'd0, 16'd7, MODE_ONE, 64'h0, 1'b0);
        send_request(KIND_ADD, 16'h0001, 3'd0, 16'd7, MODE_ONE, 64'h0, 1'b0);
        send_request(KIND_ADD, 16'h0002, 3'd3, 16'd0, MODE_PASS, 64'h0, 1'b0);
        send_request(KIND_REQUEST, 16'h0000, 3'd0, 16'd0, MODE_ONE, 64'h5, 1'b0);
        send_request(KIND_REQUEST, 16'h0000, 3'd0, 16'd0, MODE_ONE, 64'h5, 1'b1);
        send_request(KIND_REQUEST, 16'h0000, 3'd0, 16'd0, MODE_ONE, 64'h5, 1'b1);
        send_request(KIND_REQUEST, 16'h0001, 3'd0, 16'd0, MODE_ONE, 64'h5, 1'b1);
        send_request(KIND_REQUEST, 16'h0001, 3'd0, 16'd0, MODE_ONE, 64'h5, 1'b1);
        send_request(KIND_REQUEST, 16'hffff, 3'd7, 16'd0, MODE_ONE, '1, 1'b1);
        send_request(KIND_REQUEST, 16'hffff, 3'd7, 16'd0, MODE_ONE, '1, 1'b1);
        send_request(KIND_REQUEST, 16'h1234, 3'd7, 16'd0, MODE_ONE, '1, 1'b1);
        send_request(KIND_REQUEST, 16'h0002, 3'd3, 16'd0, MODE_ONE, 64'h9, 1'b1);
        send_request(KIND_REQUEST, 16'h0002, 3'd3, 16'd0, MODE_ONE, 64'h9, 1'b1);
        send_request(KIND_REMOVE, 16'h0000, 3'd0, 16'd0, MODE_ONE, 64'h0, 1'b0);
        send_request(KIND_REMOVE, 16'hffff, 3'd7, 16'd0, MODE_ONE, 64'h0, 1'b0);
        send_request(KIND_REMOVE, 16'h4444, 3'd3, 16'd0, MODE_ONE, 64'h0, 1'b0);
        // fill one group past its capacity
        for (int i = 0; i < 17; i++)
            send_request(KIND_ADD, 16'(16'h100 + i), 3'd5, 16'd2, MODE_ONE, 64'h0, 1'b0);
        drain();

        // long receiver hold-off while requests keep coming
        long_hold <= 1'b1;
        for (int i = 0; i < 10; i++)
            send_request(KIND_REQUEST, 16'(16'h100 + i), 3'd5, 16'd0, MODE_ONE,
                         64'(i), 1'b1);
        wait (hold_done);
        long_hold <= 1'b0;
        drain();

        // random phase: small id pool per group for many hits
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 4; j++) ids[i][j] = 16'($urandom);
        for (int n = 0; n < 1100; n++) begin
            logic [63:0] tag;
            logic [1:0] kind;
            k = $urandom_range(0, 99);
            g = $urandom_range(0, 7);
            tag = {$urandom, $urandom};
            if ($urandom_range(0, 1)) tag = 64'($urandom_range(0, 5));
            if (k < 25) kind = KIND_ADD;
            else if (k < 37) kind = KIND_REMOVE;
            else if (k < 97) kind = KIND_REQUEST;
            else kind = KIND_NOP;
            send_request(kind,
                         ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                       : ids[g][$urandom_range(0, 3)],
                         3'(g), 16'($urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 3)),
                         2'($urandom), tag, ($urandom_range(0, 9) != 0));
            if (n % 300 == 299) drain();
        end
        drain();

        if (fail_count == 0 && pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/grrud_pkg.sv
rtl/grrud_ram.sv
rtl/grrud_core.sv
rtl/group_round_robin_update_distributor.sv
tb/distributor_checker.sv
tb/testbench.sv
